// File: src/mlfq_pkg.sv
// Shared types and constants for the multilevel feedback thread scheduler.
`default_nettype none
package mlfq_pkg;
	localparam int LEVELS_DEF = 4;
	localparam int MAX_THREADS_DEF = 16;
	localparam int REQ_W = 3;
	localparam int ID_W = 4;
	localparam int VAL_W = 32;
	localparam int STAT_W = 2;

	localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_TICK   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PARK   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_EXIT   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_JOIN   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_IDLE    = 2'd2;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd3;

	// Controller commands to the datapath.
	typedef struct packed {
		logic capture;   // latch request fields, read done value
		logic execute;   // apply the request to the state
		logic fetch;     // present the queue memory read for dispatch
	} mlfq_cmd_t;

	typedef struct packed {
		logic dummy;
	} mlfq_stat_t;
endpackage
`default_nettype wire

// File: src/mlfq_datapath.sv
// Queue memory, level bookkeeping, done table and result registers.
`default_nettype none
module mlfq_datapath #(
	parameter int LEVELS = mlfq_pkg::LEVELS_DEF,
	parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mlfq_pkg::mlfq_cmd_t cmd,
	input  wire logic [mlfq_pkg::REQ_W-1:0] req_type,
	input  wire logic [mlfq_pkg::ID_W-1:0] thread_id,
	input  wire logic [mlfq_pkg::VAL_W-1:0] exit_value,
	output logic running_valid,
	output logic [mlfq_pkg::ID_W-1:0] running_id,
	output logic found,
	output logic [mlfq_pkg::VAL_W-1:0] join_value,
	output logic [mlfq_pkg::STAT_W-1:0] status
);
	import mlfq_pkg::*;
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW = $clog2(MAX_THREADS + 1);
	localparam int SW = CW + 1;
	localparam int AW = $clog2(LEVELS * MAX_THREADS);

	logic [ID_W-1:0] fifo_mem [LEVELS*MAX_THREADS];
	logic [VAL_W-1:0] done_mem [MAX_THREADS];
	logic [PW-1:0] head_q [LEVELS];
	logic [CW-1:0] count_q [LEVELS];
	logic [LW-1:0] tlev_q [MAX_THREADS];
	logic [MAX_THREADS-1:0] done_q;
	logic [ID_W-1:0] cur_id_q;
	logic cur_valid_q;

	logic [REQ_W-1:0] req_q;
	logic [ID_W-1:0] id_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] done_rd_q;
	logic [ID_W-1:0] head_rd_q;

	// Index helpers
	logic id_ok;
	logic [PW-1:0] id_ix, cur_ix;
	logic cur_ok;
	assign id_ok = (32'(id_q) < MAX_THREADS);
	assign id_ix = PW'(id_q);
	assign cur_ok = cur_valid_q && (32'(cur_id_q) < MAX_THREADS);
	assign cur_ix = PW'(cur_id_q);

	// Priority pick of the lowest-numbered non-empty level; a create or tick push can change it
	logic push_en;
	logic [LW-1:0] push_lv;
	logic push_full;
	logic [LW-1:0] cur_lv, dem_lv;
	always_comb begin
		cur_lv = tlev_q[cur_ix];
		dem_lv = (32'(cur_lv) + 1 < LEVELS) ? LW'(cur_lv + 1'b1) : LW'(LEVELS - 1);
		push_en = 1'b0;
		push_lv = '0;
		case (req_q)
			REQ_CREATE: begin
				push_en = id_ok;
				push_lv = '0;
			end
			REQ_TICK: begin
				push_en = cur_ok;
				push_lv = dem_lv;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
		push_full = (32'(count_q[push_lv]) >= MAX_THREADS);
	end

	logic pick_any;
	logic [LW-1:0] pick_lv;
	logic pick_from_push;
	always_comb begin
		pick_any = 1'b0;
		pick_lv = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0 || (push_en && !push_full && push_lv == LW'(l))) begin
				pick_any = 1'b1;
				pick_lv = LW'(l);
			end
		end
		pick_from_push = (count_q[pick_lv] == '0);
	end

	// Tail slot of the push level, wrapped by compare and subtract
	logic [SW-1:0] push_sum;
	logic [PW-1:0] push_pos;
	assign push_sum = SW'(head_q[push_lv]) + SW'(count_q[push_lv]);
	assign push_pos = (32'(push_sum) >= MAX_THREADS) ?
		PW'(32'(push_sum) - MAX_THREADS) : PW'(push_sum);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			id_q <= thread_id;
			val_q <= exit_value;
			done_rd_q <= done_mem[PW'(thread_id)];
		end
		if (cmd.fetch)
			head_rd_q <= fifo_mem[AW'((32'(pick_lv) * MAX_THREADS) + 32'(head_q[pick_lv]))];
		if (cmd.execute && push_en && !push_full)
			fifo_mem[AW'((32'(push_lv) * MAX_THREADS) + 32'(push_pos))] <=
				(req_q == REQ_CREATE) ? id_q : cur_id_q;
		if (cmd.execute && req_q == REQ_EXIT && cur_ok)
			done_mem[cur_ix] <= val_q;
	end

	// State update and result formation
	logic do_dispatch;
	always_comb begin
		do_dispatch = (req_q == REQ_PARK) || (req_q == REQ_EXIT) ||
			(req_q == REQ_TICK && !(push_en && push_full));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				count_q[l] <= '0;
			end
			for (int t = 0; t < MAX_THREADS; t++)
				tlev_q[t] <= '0;
			done_q <= '0;
			cur_id_q <= '0;
			cur_valid_q <= 1'b1;
			running_valid <= 1'b0;
			running_id <= '0;
			found <= 1'b0;
			join_value <= '0;
			status <= ST_OK;
		end else if (cmd.execute) begin
			found <= 1'b0;
			join_value <= '0;
			status <= ST_OK;
			if (push_en && push_full)
				status <= ST_FULL;
			if (push_en && !push_full) begin
				if (req_q == REQ_CREATE)
					tlev_q[id_ix] <= '0;
				else
					tlev_q[cur_ix] <= push_lv;
			end
			if (req_q == REQ_EXIT && cur_ok)
				done_q[cur_ix] <= 1'b1;
			if ((req_q == REQ_CREATE || req_q == REQ_JOIN) && !id_ok)
				status <= ST_INVALID;
			if (req_q > REQ_JOIN)
				status <= ST_INVALID;
			if (req_q == REQ_JOIN && id_ok && done_q[id_ix]) begin
				found <= 1'b1;
				join_value <= done_rd_q;
				done_q[id_ix] <= 1'b0;
			end
			// Count bookkeeping: push and pop on possibly the same level
			for (int l = 0; l < LEVELS; l++) begin
				count_q[l] <= count_q[l]
					+ CW'(push_en && !push_full && push_lv == LW'(l))
					- CW'(do_dispatch && pick_any && pick_lv == LW'(l));
				if (do_dispatch && pick_any && pick_lv == LW'(l))
					head_q[l] <= (32'(head_q[l]) + 1 >= MAX_THREADS) ?
						'0 : PW'(32'(head_q[l]) + 1);
			end
			if (do_dispatch) begin
				if (pick_any) begin
					cur_valid_q <= 1'b1;
					cur_id_q <= pick_from_push ? cur_id_q : head_rd_q;
					running_valid <= 1'b1;
					running_id <= pick_from_push ? cur_id_q : head_rd_q;
				end else begin
					cur_valid_q <= 1'b0;
					cur_id_q <= '0;
					running_valid <= 1'b0;
					running_id <= '0;
					status <= ST_IDLE;
				end
			end else begin
				running_valid <= cur_valid_q;
				running_id <= cur_valid_q ? cur_id_q : '0;
			end
		end
	end
endmodule
`default_nettype wire

// File: src/mlfq_ctrl.sv
// Handshake controller that sequences capture, fetch, execute and result.
`default_nettype none
module mlfq_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	output mlfq_pkg::mlfq_cmd_t cmd
);
	import mlfq_pkg::*;
	typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC} state_t;
	state_t state_q;

	// Accept in the idle state when no result is pending or it leaves this cycle
	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	always_comb begin
		cmd.capture = in_valid && in_ready;
		cmd.fetch = (state_q == S_FETCH);
		cmd.execute = (state_q == S_EXEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.capture) state_q <= S_FETCH;
				S_FETCH: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/multilevel_feedback_thread_scheduler.sv
// Top level of the multilevel feedback thread scheduler.
// Input channel (in_valid/in_ready) carries one request transaction:
// req_type, thread_id, exit_value. Output channel (out_valid/out_ready)
// returns one result per request: running_valid, running_id, found,
// join_value, status.
// A request is handled in order: queue memory head read, then state update,
// after which the result is presented. No new request is taken until the
// previous one has gone through both steps. A new request may be taken
// while the previous result still waits, once that result is taken in the
// same cycle.
// Reset: all level queues empty, done map cleared, thread 0 running.
// When the receiver stalls, the result holds and no new request is taken.
`default_nettype none
module multilevel_feedback_thread_scheduler #(
	parameter int LEVELS = mlfq_pkg::LEVELS_DEF,
	parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [mlfq_pkg::REQ_W-1:0] req_type,
	input  wire logic [mlfq_pkg::ID_W-1:0] thread_id,
	input  wire logic [mlfq_pkg::VAL_W-1:0] exit_value,
	output logic out_valid,
	input  wire logic out_ready,
	output logic running_valid,
	output logic [mlfq_pkg::ID_W-1:0] running_id,
	output logic found,
	output logic [mlfq_pkg::VAL_W-1:0] join_value,
	output logic [mlfq_pkg::STAT_W-1:0] status
);
	import mlfq_pkg::*;
	mlfq_cmd_t cmd;

	mlfq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	mlfq_datapath #(.LEVELS(LEVELS), .MAX_THREADS(MAX_THREADS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req_type(req_type),
		.thread_id(thread_id), .exit_value(exit_value),
		.running_valid(running_valid), .running_id(running_id), .found(found),
		.join_value(join_value), .status(status)
	);

	// Result becomes valid exactly after an execute step
	a_exec_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> out_valid) else $error("result not raised");
	// Execute follows fetch
	a_fetch_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> cmd.execute) else $error("fetch not followed by execute");
	// Found implies zero status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (status == ST_OK)) else $error("found with bad status");
endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the multilevel feedback thread scheduler.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mlfq_pkg::*;

	localparam int NLEV = LEVELS_DEF;
	localparam int NTHR = MAX_THREADS_DEF;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic [ID_W-1:0] id;
		logic [VAL_W-1:0] val;
	} sched_req_t;

	typedef struct packed {
		logic rv;
		logic [ID_W-1:0] rid;
		logic fnd;
		logic [VAL_W-1:0] jval;
		logic [STAT_W-1:0] st;
	} sched_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = '0;
	logic [ID_W-1:0] thread_id = '0;
	logic [VAL_W-1:0] exit_value = '0;
	logic out_valid;
	logic out_ready = 0;
	logic running_valid;
	logic [ID_W-1:0] running_id;
	logic found;
	logic [VAL_W-1:0] join_value;
	logic [STAT_W-1:0] status;

	multilevel_feedback_thread_scheduler dut (.*);

	always #6 clk = ~clk;

	// Predictor state
	logic [ID_W-1:0] lq [NLEV][NTHR];
	int lhead [NLEV];
	int lcnt [NLEV];
	int tlev [NTHR];
	bit dmap [NTHR];
	logic [VAL_W-1:0] dval [NTHR];
	logic [ID_W-1:0] cur_id;
	bit cur_vld;

	sched_req_t pending_reqs[$];
	sched_res_t expected_results[$];
	int mismatches = 0;
	bit quiet = 0;      // no random idling
	bit rx_hold = 0;    // receiver held off
	bit tx_pause = 0;   // sender held off

	function automatic bit enqueue_level(int lv, logic [ID_W-1:0] id);
		if (lcnt[lv] >= NTHR) return 0;
		lq[lv][(lhead[lv] + lcnt[lv]) % NTHR] = id;
		lcnt[lv]++;
		return 1;
	endfunction

	function automatic void pick_next();
		for (int lv = 0; lv < NLEV; lv++)
			if (lcnt[lv] != 0) begin
				cur_id = lq[lv][lhead[lv]];
				lhead[lv] = (lhead[lv] + 1) % NTHR;
				lcnt[lv]--;
				cur_vld = 1;
				return;
			end
		cur_vld = 0;
		cur_id = '0;
	endfunction

	function automatic sched_res_t schedule_step(sched_req_t r);
		sched_res_t o;
		int lv;
		o = '0;
		case (r.req)
			REQ_CREATE: begin
				if (!enqueue_level(0, r.id)) o.st = ST_FULL;
				else tlev[r.id] = 0;
			end
			REQ_TICK, REQ_PARK, REQ_EXIT: begin
				if (r.req == REQ_TICK && cur_vld) begin
					lv = tlev[cur_id] + 1 < NLEV ? tlev[cur_id] + 1 : NLEV - 1;
					if (!enqueue_level(lv, cur_id)) o.st = ST_FULL;
					else tlev[cur_id] = lv;
				end
				if (r.req == REQ_EXIT && cur_vld) begin
					dmap[cur_id] = 1;
					dval[cur_id] = r.val;
				end
				if (o.st != ST_FULL) begin
					pick_next();
					if (!cur_vld) o.st = ST_IDLE;
				end
			end
			REQ_JOIN: begin
				if (dmap[r.id]) begin
					o.fnd = 1;
					o.jval = dval[r.id];
					dmap[r.id] = 0;
				end
			end
			default: o.st = ST_INVALID;
		endcase
		o.rv = cur_vld;
		o.rid = cur_vld ? cur_id : '0;
		return o;
	endfunction

	// Driver: present pending items, hold until the transaction completes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(schedule_step({req_type, thread_id, exit_value}));
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && !tx_pause
						&& (quiet || $urandom_range(99) >= 12)) begin
					sched_req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1;
					req_type <= r.req;
					thread_id <= r.id;
					exit_value <= r.val;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sched_res_t got, exp_r;
				got = {running_valid, running_id, found, join_value, status};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", got);
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp rv=%0d id=%0d f=%0d jv=%h st=%0d",
								" / got rv=%0d id=%0d f=%0d jv=%h st=%0d"},
								exp_r.rv, exp_r.rid, exp_r.fnd, exp_r.jval, exp_r.st,
								got.rv, got.rid, got.fnd, got.jval, got.st);
					end
				end
			end
			out_ready <= !rx_hold && (quiet || $urandom_range(99) >= 12);
		end
	end

	// Watchdog: count cycles without any transaction
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || rx_hold || tx_pause)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_req(logic [REQ_W-1:0] rq, logic [ID_W-1:0] id, logic [VAL_W-1:0] v);
		sched_req_t r;
		r.req = rq;
		r.id = id;
		r.val = v;
		pending_reqs.push_back(r);
	endtask

	// Sample on the falling edge so driver and monitor updates have settled
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int pick;
		for (int l = 0; l < NLEV; l++) begin
			lhead[l] = 0;
			lcnt[l] = 0;
		end
		for (int t = 0; t < NTHR; t++) begin
			tlev[t] = 0;
			dmap[t] = 0;
			dval[t] = '0;
		end
		cur_id = '0;
		cur_vld = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, every request, full level, idle, invalid codes
		add_req(REQ_JOIN, 4'd15, 32'hFFFF_FFFF);
		add_req(REQ_EXIT, 4'd0, 32'hFFFF_FFFF);
		add_req(REQ_TICK, 4'd0, 32'h0);
		add_req(REQ_PARK, 4'd0, 32'h0);
		add_req(REQ_EXIT, 4'd0, 32'h0);
		add_req(REQ_JOIN, 4'd0, 32'h0);
		add_req(REQ_JOIN, 4'd0, 32'h0);
		add_req(3'd5, 4'd3, 32'h1);
		add_req(3'd6, 4'd3, 32'h1);
		add_req(3'd7, 4'd15, 32'hA5A5_5A5A);
		for (int i = 0; i < 17; i++) add_req(REQ_CREATE, i[3:0], 32'h0);
		add_req(REQ_TICK, 4'd0, 32'h0);
		add_req(REQ_EXIT, 4'd0, 32'h1234_5678);
		add_req(REQ_EXIT, 4'd0, 32'h8765_4321);
		wait_drained();

		// Sender pause until every result is in, then receiver hold-off
		tx_pause = 1;
		repeat (20) @(posedge clk);
		tx_pause = 0;
		rx_hold = 1;
		for (int i = 0; i < 12; i++) add_req(REQ_TICK, 4'd0, $urandom);
		repeat (150) @(posedge clk);
		rx_hold = 0;
		wait_drained();

		// Random: mostly well-formed traffic, some invalid codes
		for (int i = 0; i < 950; i++) begin
			if (i == 300) begin
				wait_drained();
				quiet = 1;
			end
			if (i == 450) quiet = 0;
			pick = $urandom_range(99);
			if (pick < 30) add_req(REQ_CREATE, ID_W'($urandom), $urandom);
			else if (pick < 55) add_req(REQ_TICK, ID_W'($urandom), $urandom);
			else if (pick < 65) add_req(REQ_PARK, ID_W'($urandom), $urandom);
			else if (pick < 80) add_req(REQ_EXIT, ID_W'($urandom), $urandom);
			else if (pick < 96) add_req(REQ_JOIN, ID_W'($urandom), $urandom);
			else add_req(REQ_W'($urandom_range(7, 5)), ID_W'($urandom), $urandom);
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// File: sim.f
src/mlfq_pkg.sv
src/mlfq_datapath.sv
src/mlfq_ctrl.sv
src/multilevel_feedback_thread_scheduler.sv
test/testbench.sv
